// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/rcs_pkg.sv =====
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared constants, types and helper functions of the Richardson solver.
// ----------------------------------------------------------------------------
`default_nettype none

package rcs_pkg;

   localparam int MAX_SIZE    = 16;
   localparam int POWER_STEPS = 50;
   localparam int IDX_W       = $clog2(MAX_SIZE);
   localparam int CNT_W       = $clog2(MAX_SIZE + 1);
   localparam int STEP_W      = $clog2(POWER_STEPS + 1);
   localparam int ACC_W       = 56;
   localparam int DIV_W       = 48;

   localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

   localparam logic [1:0] OP_LOAD_A = 2'd0;
   localparam logic [1:0] OP_LOAD_B = 2'd1;
   localparam logic [1:0] OP_START  = 2'd2;

   localparam logic [2:0] CSR_SIZE  = 3'd0;
   localparam logic [2:0] CSR_STEP  = 3'd1;
   localparam logic [2:0] CSR_AUTO  = 3'd2;
   localparam logic [2:0] CSR_TOL   = 3'd3;
   localparam logic [2:0] CSR_LIMIT = 3'd4;

   typedef enum logic [1:0] {
      ROT_HOLD, ROT_SHIFT, ROT_LOAD_X, ROT_LOAD_PV
   } rot_op_type;

   typedef enum logic [1:0] {
      MUL_IDLE, MUL_SQ, MUL_UPD
   } mul_op_type;

   typedef enum logic [2:0] {
      SH_HOLD, SH_SHIFT, SH_LOAD_SQ, SH_LOAD_VAL, SH_LOAD_X
   } sh_op_type;

   typedef struct packed {
      rot_op_type               rot_op;
      logic                     mac_issue;
      logic                     acc_clr;
      logic                     res_en;
      logic                     sub_b;
      mul_op_type               mul_op;
      logic                     x_upd;
      sh_op_type                sh_op;
      logic                     pv_commit;
      logic                     vec_init;
      logic [CNT_W-1:0]         n;
      logic signed [31:0]       tau;
   } cell_ctl_type;

   typedef struct packed {
      logic                     a_en;
      logic                     b_en;
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         column;
      logic signed [31:0]       value;
   } cell_wr_type;

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      if (v > ACC_W'(SAT_MAX)) begin
         r = SAT_MAX;
      end else if (v < ACC_W'(SAT_MIN)) begin
         r = SAT_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/rcs_req_if.sv =====
// ----------------------------------------------------------------------------
// rcs_req_if
// Request channel: load and start beats into the solver.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcs_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic [3:0]         row;
   logic [3:0]         column;
   logic signed [31:0] value;

   modport source (output valid, operation, row, column, value, input ready);
   modport sink   (input valid, operation, row, column, value, output ready);
endinterface

`default_nettype wire

// ===== src/rcs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rcs_rsp_if
// Response channel: one beat per solution entry.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcs_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         index;
   logic signed [31:0] solution;
   logic               last;
   logic               converged;
   logic [15:0]        iterations_used;

   modport source (output valid, index, solution, last, converged, iterations_used,
                   input ready);
   modport sink   (input valid, index, solution, last, converged, iterations_used,
                   output ready);
endinterface

`default_nettype wire

// ===== src/richardson_iteration_solver.sv =====
// A start beat on the request channel solves A x = b by Richardson iteration
// over the entries loaded earlier, and the block then returns n response
// beats, one per solution entry. Load beats are taken one per cycle while the
// block is idle. Each iteration makes a multiply-accumulate pass through the
// row of cells and a pass of the squares along the cell chain; in auto mode a
// start first spends 50 power steps, each using the serial square root once
// and the serial divider once per entry, and then one more division for the
// step size. New requests wait until the last response beat has been loaded
// into the output register.
`default_nettype none

module richardson_iteration_solver import rcs_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   rcs_req_if.sink    req_chan,
   rcs_rsp_if.source  rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [30:0] csr_wr_data
);

   typedef enum logic [18:0] {
      ST_IDLE    = 19'h00001,
      ST_INIT    = 19'h00002,
      ST_LOAD    = 19'h00004,
      ST_MAC     = 19'h00008,
      ST_DRAIN   = 19'h00010,
      ST_RES     = 19'h00020,
      ST_SQM     = 19'h00040,
      ST_SQL     = 19'h00080,
      ST_SUM     = 19'h00100,
      ST_SQRT    = 19'h00200,
      ST_VAL     = 19'h00400,
      ST_DIV     = 19'h00800,
      ST_COMMIT  = 19'h01000,
      ST_TAU     = 19'h02000,
      ST_CHK     = 19'h04000,
      ST_UPM     = 19'h08000,
      ST_UPD     = 19'h10000,
      ST_EMIT_LD = 19'h20000,
      ST_EMIT    = 19'h40000
   } state_type;

   state_type          state_ff;
   logic [4:0]         size_ff;
   logic [30:0]        step_factor_ff, tol_ff;
   logic               auto_ff;
   logic [15:0]        limit_ff;

   logic [CNT_W-1:0]   n_ff, cnt_ff, n_eff, n_last;
   logic [STEP_W-1:0]  step_ff;
   logic [15:0]        iter_ff;
   logic               power_ff, wait_ff, conv_ff;
   logic [63:0]        sumsq_ff, eps_sq_ff;
   logic [64:0]        sum_wide;
   logic [30:0]        lambda_ff;
   logic signed [31:0] tau_ff;

   logic               rsp_valid_ff, rsp_last_ff, rsp_conv_ff;
   logic [3:0]         rsp_index_ff;
   logic signed [31:0] rsp_sol_ff;
   logic [15:0]        rsp_iter_ff;

   cell_ctl_type       ctl;
   cell_wr_type        wr;
   logic signed [31:0] rot_w [MAX_SIZE];
   logic [63:0]        sh_w  [MAX_SIZE];
   logic [63:0]        sh_feed;

   logic               div_start, div_busy, sqrt_start, sqrt_busy;
   logic [DIV_W-1:0]   div_dividend, div_quot;
   logic [31:0]        sqrt_root;
   logic               req_fire, emit_go, av_neg;
   logic [32:0]        av_mag;
   logic signed [31:0] pv_new;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign n_eff    = (size_ff == '0) ? CNT_W'(1) :
                     (size_ff > 5'(MAX_SIZE)) ? CNT_W'(MAX_SIZE) : CNT_W'(size_ff);
   assign n_last   = n_ff - 1'b1;
   assign sum_wide = {1'b0, sumsq_ff} + {1'b0, sh_w[0]};
   assign emit_go  = !rsp_valid_ff || rsp_chan.ready;

   // Entry being divided sits at the head of the shift chain.
   assign av_neg   = sh_w[0][31];
   assign av_mag   = av_neg ? 33'(-33'($signed(sh_w[0][31:0]))) :
                              33'($signed(sh_w[0][31:0]));
   assign pv_new   = sat32(av_neg ? -ACC_W'(div_quot) : ACC_W'(div_quot));

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff        <= 5'd16;
         step_factor_ff <= 31'd65536;
         auto_ff        <= 1'b1;
         tol_ff         <= 31'd66;
         limit_ff       <= 16'd1000;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SIZE:  size_ff        <= csr_wr_data[4:0];
            CSR_STEP:  step_factor_ff <= csr_wr_data;
            CSR_AUTO:  auto_ff        <= csr_wr_data[0];
            CSR_TOL:   tol_ff         <= csr_wr_data;
            CSR_LIMIT: limit_ff       <= csr_wr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      wr.a_en   = req_fire && req_chan.operation == OP_LOAD_A;
      wr.b_en   = req_fire && req_chan.operation == OP_LOAD_B;
      wr.row    = req_chan.row;
      wr.column = req_chan.column;
      wr.value  = req_chan.value;
   end

   always_comb begin
      ctl           = '0;
      ctl.rot_op    = ROT_HOLD;
      ctl.mul_op    = MUL_IDLE;
      ctl.sh_op     = SH_HOLD;
      ctl.n         = n_ff;
      ctl.tau       = tau_ff;
      sh_feed       = '0;
      div_start     = 1'b0;
      div_dividend  = {av_mag[31:0], 16'd0};
      sqrt_start    = 1'b0;
      unique case (state_ff)
         ST_INIT:   ctl.vec_init = 1'b1;
         ST_LOAD: begin
            ctl.rot_op  = power_ff ? ROT_LOAD_PV : ROT_LOAD_X;
            ctl.acc_clr = 1'b1;
         end
         ST_MAC: begin
            ctl.mac_issue = 1'b1;
            ctl.rot_op    = ROT_SHIFT;
         end
         ST_RES: begin
            ctl.res_en = 1'b1;
            ctl.sub_b  = !power_ff;
         end
         ST_SQM:     ctl.mul_op = MUL_SQ;
         ST_SQL:     ctl.sh_op  = SH_LOAD_SQ;
         ST_SUM:     ctl.sh_op  = SH_SHIFT;
         ST_SQRT:    sqrt_start = !wait_ff;
         ST_VAL:     ctl.sh_op  = SH_LOAD_VAL;
         ST_DIV: begin
            if (lambda_ff == '0) begin
               ctl.sh_op = SH_SHIFT;
            end else if (!wait_ff) begin
               div_start = 1'b1;
            end else if (!div_busy) begin
               ctl.sh_op = SH_SHIFT;
               sh_feed   = 64'(pv_new);
            end
         end
         ST_COMMIT:  ctl.pv_commit = 1'b1;
         ST_TAU: begin
            div_dividend = DIV_W'(64'd1 << 32);
            div_start    = lambda_ff != '0 && !wait_ff;
         end
         ST_UPM:     ctl.mul_op = MUL_UPD;
         ST_UPD:     ctl.x_upd  = 1'b1;
         ST_EMIT_LD: ctl.sh_op  = SH_LOAD_X;
         ST_EMIT:    ctl.sh_op  = emit_go ? SH_SHIFT : SH_HOLD;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tau_ff       <= '0;
      end else begin
         if (state_ff == ST_EMIT && emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_chan.operation == OP_START) begin
                  n_ff     <= n_eff;
                  state_ff <= ST_INIT;
               end
            end
            ST_INIT: begin
               eps_sq_ff <= 64'(tol_ff) * 64'(tol_ff);
               step_ff   <= '0;
               iter_ff   <= '0;
               conv_ff   <= 1'b0;
               power_ff  <= auto_ff;
               if (!auto_ff) begin
                  tau_ff <= $signed({1'b0, step_factor_ff});
               end
               state_ff  <= ST_LOAD;
            end
            ST_LOAD: begin
               cnt_ff <= '0;
               if (!power_ff && iter_ff == limit_ff) begin
                  state_ff <= ST_EMIT_LD;
               end else begin
                  state_ff <= ST_MAC;
               end
            end
            ST_MAC: begin
               if (cnt_ff == n_last) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_DRAIN;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               // Waits out the read and multiply stages in each cell.
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= ST_RES;
               end
            end
            ST_RES:  state_ff <= ST_SQM;
            ST_SQM:  state_ff <= ST_SQL;
            ST_SQL: begin
               cnt_ff   <= '0;
               sumsq_ff <= '0;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               sumsq_ff <= sum_wide[64] ? '1 : sum_wide[63:0];
               cnt_ff   <= cnt_ff + 1'b1;
               if (cnt_ff == n_last) begin
                  state_ff <= power_ff ? ST_SQRT : ST_CHK;
               end
            end
            ST_SQRT: begin
               if (!wait_ff) begin
                  wait_ff <= 1'b1;
               end else if (!sqrt_busy) begin
                  wait_ff   <= 1'b0;
                  lambda_ff <= sqrt_root[31] ? 31'h7FFF_FFFF : sqrt_root[30:0];
                  state_ff  <= ST_VAL;
               end
            end
            ST_VAL: begin
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (lambda_ff == '0 || (wait_ff && !div_busy)) begin
                  wait_ff <= 1'b0;
                  cnt_ff  <= cnt_ff + 1'b1;
                  if (cnt_ff == n_last) begin
                     state_ff <= ST_COMMIT;
                  end
               end else if (!wait_ff) begin
                  wait_ff <= 1'b1;
               end
            end
            ST_COMMIT: begin
               step_ff  <= step_ff + 1'b1;
               state_ff <= (step_ff == STEP_W'(POWER_STEPS - 1)) ? ST_TAU : ST_LOAD;
            end
            ST_TAU: begin
               if (lambda_ff == '0) begin
                  tau_ff   <= SAT_MAX;
                  power_ff <= 1'b0;
                  state_ff <= ST_LOAD;
               end else if (!wait_ff) begin
                  wait_ff <= 1'b1;
               end else if (!div_busy) begin
                  wait_ff  <= 1'b0;
                  tau_ff   <= (div_quot > DIV_W'(SAT_MAX)) ? SAT_MAX : div_quot[31:0];
                  power_ff <= 1'b0;
                  state_ff <= ST_LOAD;
               end
            end
            ST_CHK: begin
               if (sumsq_ff < eps_sq_ff) begin
                  conv_ff  <= 1'b1;
                  state_ff <= ST_EMIT_LD;
               end else begin
                  state_ff <= ST_UPM;
               end
            end
            ST_UPM:  state_ff <= ST_UPD;
            ST_UPD: begin
               iter_ff  <= iter_ff + 1'b1;
               state_ff <= ST_LOAD;
            end
            ST_EMIT_LD: begin
               cnt_ff   <= '0;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (emit_go) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff == n_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && emit_go) begin
         rsp_index_ff <= 4'(cnt_ff);
         rsp_sol_ff   <= sh_w[0][31:0];
         rsp_last_ff  <= cnt_ff == n_last;
         rsp_conv_ff  <= conv_ff;
         rsp_iter_ff  <= iter_ff;
      end
   end

   for (genvar i = 0; i < MAX_SIZE; i++) begin : g_cell
      logic signed [31:0] rot_in;
      logic [63:0]        sh_in;
      assign rot_in = (CNT_W'(i) == n_last) ? rot_w[0] : rot_w[(i + 1) % MAX_SIZE];
      assign sh_in  = (CNT_W'(i) == n_last) ? sh_feed  : sh_w[(i + 1) % MAX_SIZE];
      rcs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .ctl        (ctl),
         .wr         (wr),
         .rot_in     (rot_in),
         .rot_out    (rot_w[i]),
         .sh_in      (sh_in),
         .sh_out     (sh_w[i])
      );
   end

   rcs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (lambda_ff),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   rcs_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (sumsq_ff),
      .busy    (sqrt_busy),
      .root    (sqrt_root)
   );

   assign req_chan.ready           = state_ff == ST_IDLE;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.index           = rsp_index_ff;
   assign rsp_chan.solution        = rsp_sol_ff;
   assign rsp_chan.last            = rsp_last_ff;
   assign rsp_chan.converged       = rsp_conv_ff;
   assign rsp_chan.iterations_used = rsp_iter_ff;

endmodule

`default_nettype wire

// ===== src/rcs_cell.sv =====
// ----------------------------------------------------------------------------
// rcs_cell
// One row cell: holds a matrix row and the row's vector entries, does the
// multiply-accumulate of the row product and passes vectors to its neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_cell import rcs_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [IDX_W-1:0]   cell_index,
   input  wire cell_ctl_type       ctl,
   input  wire cell_wr_type        wr,
   input  wire logic signed [31:0] rot_in,
   output logic signed [31:0]      rot_out,
   input  wire logic [63:0]        sh_in,
   output logic [63:0]             sh_out
);

   logic signed [31:0]      a_mem [MAX_SIZE];
   logic signed [31:0]      b_ff, x_ff, pv_ff, rot_ff, rot_d_ff, a_rd_ff, val_ff;
   logic [IDX_W-1:0]        col_ff;
   logic                    mv_ff, acc_v_ff;
   logic signed [63:0]      p_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [63:0]             sh_ff;
   logic signed [31:0]      mul_a, mul_b;
   logic                    mul_en;
   logic signed [ACC_W-1:0] prod_q16;

   assign prod_q16 = ACC_W'(p_ff >>> 16);

   always_ff @(posedge clock) begin
      if (wr.a_en && wr.row == cell_index) begin
         a_mem[wr.column] <= wr.value;
      end
      if (ctl.mac_issue) begin
         a_rd_ff <= a_mem[col_ff];
      end
   end

   always_comb begin
      mul_en = 1'b1;
      mul_a  = a_rd_ff;
      mul_b  = rot_d_ff;
      if (!mv_ff) begin
         case (ctl.mul_op)
            MUL_SQ: begin
               mul_a = val_ff;
               mul_b = val_ff;
            end
            MUL_UPD: begin
               mul_a = ctl.tau;
               mul_b = val_ff;
            end
            default: begin
               mul_en = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff    <= 1'b0;
         acc_v_ff <= 1'b0;
      end else begin
         mv_ff    <= ctl.mac_issue;
         acc_v_ff <= mv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.b_en && wr.row == cell_index) begin
         b_ff <= wr.value;
      end
      if (ctl.vec_init) begin
         x_ff  <= '0;
         pv_ff <= ONE_Q16;
      end else begin
         if (ctl.x_upd) begin
            x_ff <= sat32(ACC_W'(x_ff) - prod_q16);
         end
         if (ctl.pv_commit) begin
            pv_ff <= sh_ff[31:0];
         end
      end

      case (ctl.rot_op)
         ROT_LOAD_X: begin
            rot_ff <= x_ff;
            col_ff <= cell_index;
         end
         ROT_LOAD_PV: begin
            rot_ff <= pv_ff;
            col_ff <= cell_index;
         end
         ROT_SHIFT: begin
            rot_ff <= rot_in;
         end
         default: begin
         end
      endcase
      if (ctl.mac_issue) begin
         rot_d_ff <= rot_ff;
         col_ff   <= ({1'b0, col_ff} == ctl.n - 1'b1) ? '0 : col_ff + 1'b1;
      end

      if (mul_en) begin
         p_ff <= 64'(mul_a) * 64'(mul_b);
      end
      if (ctl.acc_clr) begin
         acc_ff <= '0;
      end else if (acc_v_ff) begin
         acc_ff <= acc_ff + prod_q16;
      end
      if (ctl.res_en) begin
         val_ff <= sat32(acc_ff - (ctl.sub_b ? ACC_W'(b_ff) : ACC_W'(0)));
      end

      case (ctl.sh_op)
         SH_SHIFT:    sh_ff <= sh_in;
         SH_LOAD_SQ:  sh_ff <= p_ff;
         SH_LOAD_VAL: sh_ff <= 64'(val_ff);
         SH_LOAD_X:   sh_ff <= 64'(x_ff);
         default: begin
         end
      endcase
   end

   assign rot_out = rot_ff;
   assign sh_out  = sh_ff;

endmodule

`default_nettype wire

// ===== src/rcs_div.sv =====
// ----------------------------------------------------------------------------
// rcs_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_div import rcs_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [30:0]      divisor,
   output logic                  busy,
   output logic [DIV_W-1:0]      quotient
);

   logic [30:0]              rem_ff;
   logic [DIV_W-1:0]         q_ff;
   logic [30:0]              d_ff;
   logic [$clog2(DIV_W)-1:0] cnt_ff;
   logic                     busy_ff;
   logic [31:0]              trial;
   logic                     take;

   assign trial = {rem_ff, q_ff[DIV_W-1]};
   assign take  = trial >= {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == '0) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         q_ff   <= dividend;
         d_ff   <= divisor;
         cnt_ff <= ($clog2(DIV_W))'(DIV_W - 1);
      end else if (busy_ff) begin
         rem_ff <= take ? 31'(trial - {1'b0, d_ff}) : trial[30:0];
         q_ff   <= {q_ff[DIV_W-2:0], take};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

// ===== src/rcs_sqrt.sv =====
// ----------------------------------------------------------------------------
// rcs_sqrt
// Serial integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_sqrt import rcs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] operand,
   output logic             busy,
   output logic [31:0]      root
);

   logic [63:0] rem_ff, res_ff, bit_ff;
   logic        busy_ff;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && bit_ff[0]) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= operand;
         res_ff <= '0;
         bit_ff <= 64'd1 << 62;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign busy = busy_ff;
   assign root = res_ff[31:0];

endmodule

`default_nettype wire

// ===== src/rcs_checker.sv =====
// ----------------------------------------------------------------------------
// rcs_checker
// Port-level checks of the solver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rcs_checker import rcs_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_operation,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_last,
   input wire logic [31:0] rsp_solution
);

   // A stalled response beat stays valid and keeps its solution value.
   `RCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_solution))

   // Once a solve starts, no further request is taken in the next cycle.
   `RCS_ASSERT_NEXT(a_start_busy, clock, reset, req_valid && req_ready && req_operation == OP_START, !req_ready)

   // The final beat of a run is never followed at once by another beat.
   `RCS_ASSERT_NEXT(a_last_gap, clock, reset, rsp_valid && rsp_ready && rsp_last, !rsp_valid)

   // Requests are refused while a non-final beat is still pending.
   `RCS_ASSERT_SAME(a_emit_busy, clock, reset, rsp_valid && !rsp_last, !req_ready)

endmodule

bind richardson_iteration_solver rcs_checker u_rcs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_operation (req_chan.operation),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_last      (rsp_chan.last),
   .rsp_solution  (rsp_chan.solution)
);

`default_nettype wire

// ===== tb/sv/richardson_iteration_solver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// richardson_iteration_solver_tb
// Loads matrix and right-hand side entries, starts solves under a range of
// register settings and idling patterns, and checks every solution beat
// against a cycle-free Q16.16 model of the iteration kept in this bench.
// ----------------------------------------------------------------------------

module richardson_iteration_solver_tb;
   import rcs_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic [2:0] CSR_NOWHERE = 3'd7;
   localparam int         QUIET_LIMIT = 500000;
   localparam int         RANDOM_BEATS = 360;

   typedef logic signed [31:0] qvec_type [MAX_SIZE];

   typedef struct {
      logic [1:0]         operation;
      logic [3:0]         row;
      logic [3:0]         column;
      logic signed [31:0] value;
   } req_beat_type;

   typedef struct {
      logic [3:0]         index;
      logic signed [31:0] solution;
      logic               last;
      logic               converged;
      logic [15:0]        iterations_used;
   } rsp_beat_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [30:0] csr_wr_data;

   rcs_req_if req_if ();
   rcs_rsp_if rsp_if ();

   richardson_iteration_solver u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   req_beat_type pending_beats[$];
   rsp_beat_type expected_entries[$];
   int        error_count = 0;
   int        sender_idle_pct = 0;
   int        receiver_stall_pct = 0;
   int        quiet_cycles = 0;
   int        random_beats = 0;

   // Model copies of the stores and the registers.
   qvec_type           matrix_q [MAX_SIZE];
   qvec_type           rhs_q;
   logic [4:0]         size_reg;
   logic [30:0]        step_reg;
   logic               auto_reg;
   logic [30:0]        tol_reg;
   logic [15:0]        limit_reg;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic signed [31:0] clip32(longint v);
      if (v > longint'(SAT_MAX)) return SAT_MAX;
      if (v < longint'(SAT_MIN)) return SAT_MIN;
      return v[31:0];
   endfunction

   function automatic longint unsigned add_sat64(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bw;
      res = 0;
      bw = 64'd1 << 62;
      while (bw > v) bw >>= 2;
      while (bw != 0) begin
         if (v >= res + bw) begin
            v   = v - (res + bw);
            res = (res >> 1) + bw;
         end else begin
            res = res >> 1;
         end
         bw >>= 2;
      end
      return res;
   endfunction

   // Each product is floored to Q16.16 before the exact sum.
   function automatic longint row_dot(int r, qvec_type vec, int n);
      longint acc;
      acc = 0;
      for (int j = 0; j < n; j++) begin
         acc += (longint'(matrix_q[r][j]) * longint'(vec[j])) >>> 16;
      end
      return acc;
   endfunction

   function automatic int size_in_force();
      if (size_reg == 0) return 1;
      if (size_reg > MAX_SIZE) return MAX_SIZE;
      return int'(size_reg);
   endfunction

   function automatic longint step_from_eigen(int n);
      qvec_type        pv;
      qvec_type        av;
      longint          lambda;
      longint unsigned sq;
      longint unsigned root;
      longint          t;
      lambda = 0;
      for (int i = 0; i < MAX_SIZE; i++) pv[i] = (i < n) ? ONE_Q16 : 32'sd0;
      for (int s = 0; s < POWER_STEPS; s++) begin
         sq = 0;
         for (int i = 0; i < n; i++) begin
            av[i] = clip32(row_dot(i, pv, n));
            sq = add_sat64(sq, longint'(av[i]) * longint'(av[i]));
         end
         root = floor_sqrt(sq);
         lambda = (root > 64'd2147483647) ? 64'sd2147483647 : longint'(root);
         for (int i = 0; i < n; i++) begin
            pv[i] = (lambda == 0) ? 32'sd0 : clip32((longint'(av[i]) * 65536) / lambda);
         end
      end
      if (lambda == 0) return longint'(SAT_MAX);
      t = (64'sd1 <<< 32) / lambda;
      return (t > longint'(SAT_MAX)) ? longint'(SAT_MAX) : t;
   endfunction

   task automatic predict_solve();
      int              n;
      int              iter;
      longint          tau;
      longint unsigned eps_sq;
      longint unsigned sq;
      logic            conv;
      qvec_type        x;
      qvec_type        res;
      rsp_beat_type    e;
      n = size_in_force();
      tau = auto_reg ? step_from_eigen(n) : longint'(step_reg);
      for (int i = 0; i < MAX_SIZE; i++) x[i] = 32'sd0;
      eps_sq = longint'(tol_reg) * longint'(tol_reg);
      conv = 1'b0;
      for (iter = 0; iter < int'(limit_reg); iter++) begin
         sq = 0;
         for (int i = 0; i < n; i++) begin
            res[i] = clip32(row_dot(i, x, n) - longint'(rhs_q[i]));
            sq = add_sat64(sq, longint'(res[i]) * longint'(res[i]));
         end
         if (sq < eps_sq) begin
            conv = 1'b1;
            break;
         end
         for (int i = 0; i < n; i++) begin
            x[i] = clip32(longint'(x[i]) - ((tau * longint'(res[i])) >>> 16));
         end
      end
      for (int i = 0; i < n; i++) begin
         e.index           = i[3:0];
         e.solution        = x[i];
         e.last            = (i == n - 1);
         e.converged       = conv;
         e.iterations_used = iter[15:0];
         expected_entries.push_back(e);
      end
   endtask

   // Driver: presents the oldest pending beat, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) pending_beats.pop_front();
         if (pending_beats.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_if.valid     <= 1'b1;
            req_if.operation <= pending_beats[0].operation;
            req_if.row       <= pending_beats[0].row;
            req_if.column    <= pending_beats[0].column;
            req_if.value     <= pending_beats[0].value;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Request monitor: every accepted load or start beat updates the model.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         case (req_if.operation)
            OP_LOAD_A: matrix_q[req_if.row][req_if.column] = req_if.value;
            OP_LOAD_B: rhs_q[req_if.row] = req_if.value;
            OP_START:  predict_solve();
            default: ;
         endcase
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      rsp_beat_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_entries.size() == 0) begin
            $error("unexpected solution beat, index %0d", rsp_if.index);
            error_count++;
         end else begin
            e = expected_entries.pop_front();
            if (rsp_if.index !== e.index) begin
               $error("index: expected %0d, got %0d", e.index, rsp_if.index);
               error_count++;
            end
            if (rsp_if.solution !== e.solution) begin
               $error("solution: expected %0d, got %0d", e.solution, rsp_if.solution);
               error_count++;
            end
            if (rsp_if.last !== e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp_if.last);
               error_count++;
            end
            if (rsp_if.converged !== e.converged) begin
               $error("converged: expected %0d, got %0d", e.converged, rsp_if.converged);
               error_count++;
            end
            if (rsp_if.iterations_used !== e.iterations_used) begin
               $error("iterations_used: expected %0d, got %0d",
                      e.iterations_used, rsp_if.iterations_used);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [30:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      case (idx)
         CSR_SIZE:  size_reg  = data[4:0];
         CSR_STEP:  step_reg  = data;
         CSR_AUTO:  auto_reg  = data[0];
         CSR_TOL:   tol_reg   = data;
         CSR_LIMIT: limit_reg = data[15:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic setup(int n, int step, int auto_on, int tol, int limit);
      write_reg(CSR_SIZE, 31'(n));
      write_reg(CSR_STEP, 31'(step));
      write_reg(CSR_AUTO, 31'(auto_on));
      write_reg(CSR_TOL, 31'(tol));
      write_reg(CSR_LIMIT, 31'(limit));
   endtask

   task automatic push_beat(logic [1:0] op, int r, int c, int v);
      req_beat_type b;
      b.operation = op;
      b.row       = r[3:0];
      b.column    = c[3:0];
      b.value     = v;
      pending_beats.push_back(b);
      random_beats++;
   endtask

   // A diagonally dominant system, with a share of entries drawn wild.
   task automatic load_system(int n, int wild_pct, int noise_pct);
      int v;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            if (i == j) v = 131072 + int'($urandom_range(0, 131072));
            else v = int'($urandom_range(0, 16384)) - 8192;
            if ($urandom_range(0, 99) < wild_pct) v = $urandom;
            push_beat(OP_LOAD_A, i, j, v);
            if ($urandom_range(0, 99) < noise_pct)
               push_beat(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
         end
         v = int'($urandom_range(0, 1048576)) - 524288;
         if ($urandom_range(0, 99) < wild_pct) v = $urandom;
         push_beat(OP_LOAD_B, i, 0, v);
      end
   endtask

   task automatic drain(int idle_mode);
      do @(negedge clock);
      while (pending_beats.size() != 0 || expected_entries.size() != 0 || req_if.valid);
      repeat (20) @(posedge clock);
      case (idle_mode % 4)
         0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1: begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
         default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
      endcase
   endtask

   initial begin
      int phase;
      int n;
      int step;
      int tol;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wr_data      = '0;
      req_if.valid     = 1'b0;
      req_if.operation = '0;
      req_if.row       = '0;
      req_if.column    = '0;
      req_if.value     = '0;
      rsp_if.ready     = 1'b0;
      size_reg  = 5'd16;
      step_reg  = 31'd65536;
      auto_reg  = 1'b1;
      tol_reg   = 31'd66;
      limit_reg = 16'd1000;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Fill every entry once under the reset settings and solve at full size.
      load_system(MAX_SIZE, 0, 0);
      push_beat(OP_START, 0, 0, 0);
      drain(1);

      // Directed: unused operation, extreme values, register edge cases.
      push_beat(OP_UNUSED, 15, 15, 32'h8000_0000);
      push_beat(OP_LOAD_A, 15, 15, 32'h8000_0000);
      push_beat(OP_LOAD_A, 15, 0, 32'h7FFF_FFFF);
      push_beat(OP_LOAD_B, 15, 15, 32'h7FFF_FFFF);
      push_beat(OP_LOAD_B, 14, 0, 32'h8000_0000);
      drain(2);
      write_reg(CSR_NOWHERE, 31'h7FFF_FFFF);
      // Size zero acts as one; a zero step leaves x at zero.
      setup(0, 0, 0, 0, 5);
      push_beat(OP_START, 0, 0, 0);
      drain(3);
      // Oversized size, largest step, zero tolerance: saturation throughout.
      setup(31, 32'h7FFF_FFFF, 0, 0, 3);
      push_beat(OP_START, 0, 0, 0);
      drain(0);
      // Zero iteration limit.
      setup(3, 65536, 1, 66, 0);
      push_beat(OP_START, 0, 0, 0);
      drain(1);
      // Widest tolerance and longest limit: stops before the first update.
      setup(2, 65536, 1, 32'h7FFF_FFFF, 65535);
      push_beat(OP_START, 0, 0, 0);
      drain(2);
      // A zero matrix leaves the eigenvalue estimate at zero.
      setup(2, 65536, 1, 66, 4);
      push_beat(OP_LOAD_A, 0, 0, 0);
      push_beat(OP_LOAD_A, 0, 1, 0);
      push_beat(OP_LOAD_A, 1, 0, 0);
      push_beat(OP_LOAD_A, 1, 1, 0);
      push_beat(OP_START, 0, 0, 0);
      drain(3);

      // Random solves top the run up to the planned number of beats.
      phase = 0;
      while (random_beats < RANDOM_BEATS) begin
         n = $urandom_range(0, 9);
         case ($urandom_range(0, 3))
            0: step = $urandom_range(0, 65536);
            1: step = 16384;
            2: step = $urandom & 32'h7FFF_FFFF;
            default: step = $urandom_range(8192, 32768);
         endcase
         case ($urandom_range(0, 3))
            0: tol = 0;
            1: tol = 66;
            2: tol = $urandom_range(0, 65536);
            default: tol = $urandom & 32'h7FFF_FFFF;
         endcase
         setup(n, step, ($urandom_range(0, 99) < 40), tol, $urandom_range(0, 60));
         load_system((n == 0) ? 1 : n, ($urandom_range(0, 3) == 0) ? 30 : 3, 5);
         push_beat(OP_START, 0, 0, 0);
         if ($urandom_range(0, 1)) begin
            push_beat(OP_LOAD_B, 0, $urandom_range(0, 15), $urandom);
            push_beat(OP_START, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
         end
         phase++;
         drain(phase);
      end

      drain(0);
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_entries.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/rcs_pkg.sv
src/rcs_req_if.sv
src/rcs_rsp_if.sv
src/rcs_cell.sv
src/rcs_div.sv
src/rcs_sqrt.sv
src/richardson_iteration_solver.sv
src/rcs_checker.sv
tb/sv/richardson_iteration_solver_tb.sv
